>>> rtl/nfua_pkg.sv
// Types and constants shared by the nearest free unit allocator modules.
package nfua_pkg;

    localparam int IDENT_W = 16;
    localparam int CLASS_W = 3;
    localparam int LAT_W   = 28;
    localparam int LON_W   = 29;
    localparam int JOB_W   = 24;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 3;
    localparam int SLOT_W  = 6;
    localparam int BATCH_W = 7;
    localparam int SQLAT_W = 2 * LAT_W;
    localparam int SQLON_W = 2 * LON_W;
    localparam int DIST_W  = SQLON_W + 1;
    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 32;

    localparam logic [BATCH_W-1:0] BATCH_MAX = 7'd127;

    typedef enum logic [KIND_W-1:0] {
        KIND_REGISTER = 3'd0,
        KIND_DISPATCH = 3'd1,
        KIND_RELEASE  = 3'd2,
        KIND_FIND     = 3'd3,
        KIND_ALLOCATE = 3'd4
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_NOT_FOUND = 3'd2,
        STAT_BUSY      = 3'd3,
        STAT_NO_MATCH  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [JOB_W-1:0]          job;
        logic                      free;
        logic signed [LON_W-1:0]   lon;
        logic signed [LAT_W-1:0]   lat;
        logic [CLASS_W-1:0]        unit_class;
        logic [IDENT_W-1:0]        ident;
    } entry_t;

    typedef struct packed {
        logic done;
        logic found;
    } srch_stat_t;

endpackage

>>> rtl/nfua_table.sv
// Entry table: one write port, one registered read port.
module nfua_table #(
    parameter int UNITS = 64
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(UNITS)-1:0]      wr_addr,
    input  nfua_pkg::entry_t              wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(UNITS)-1:0]      rd_addr,
    output nfua_pkg::entry_t              rd_data
);

    nfua_pkg::entry_t entry_mem [UNITS];
    nfua_pkg::entry_t rd_data_reg;

    // reads and writes never target the same cycle, so no bypass is needed
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/nfua_search.sv
// Table walk with squared-distance pipeline and running best-slot tracking.
module nfua_search #(
    parameter int UNITS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [$clog2(UNITS+1)-1:0]          fill,
    input  logic                                by_ident,
    input  logic [nfua_pkg::IDENT_W-1:0]        q_ident,
    input  logic [nfua_pkg::CLASS_W-1:0]        q_class,
    input  logic signed [nfua_pkg::LAT_W-1:0]   q_lat,
    input  logic signed [nfua_pkg::LON_W-1:0]   q_lon,
    output logic                                rd_en,
    output logic [$clog2(UNITS)-1:0]            rd_addr,
    input  nfua_pkg::entry_t                    rd_data,
    output nfua_pkg::srch_stat_t                stat,
    output logic [$clog2(UNITS)-1:0]            best_slot
);

    localparam int AW = $clog2(UNITS);
    localparam int CW = $clog2(UNITS + 1);

    logic                           running_reg;
    logic [CW-1:0]                  cnt_reg;
    logic                           p0_valid_reg;
    logic [AW-1:0]                  p0_slot_reg;
    logic                           s1_valid_reg, s1_cand_reg;
    logic [AW-1:0]                  s1_slot_reg;
    logic [nfua_pkg::LAT_W-1:0]     s1_dlat_reg;
    logic [nfua_pkg::LON_W-1:0]     s1_dlon_reg;
    logic                           s2_valid_reg, s2_cand_reg;
    logic [AW-1:0]                  s2_slot_reg;
    logic [nfua_pkg::SQLAT_W-1:0]   s2_sqlat_reg;
    logic [nfua_pkg::SQLON_W-1:0]   s2_sqlon_reg;
    logic                           s3_valid_reg, s3_cand_reg;
    logic [AW-1:0]                  s3_slot_reg;
    logic [nfua_pkg::DIST_W-1:0]    s3_dist_reg;
    logic                           found_reg;
    logic [AW-1:0]                  best_slot_reg;
    logic [nfua_pkg::DIST_W-1:0]    lead_sqd_reg;

    logic                           issue;
    logic                           done;
    logic                           cand;
    logic [nfua_pkg::LAT_W:0]       lat_diff;
    logic [nfua_pkg::LON_W:0]       lon_diff;
    logic [nfua_pkg::LAT_W:0]       lat_abs;
    logic [nfua_pkg::LON_W:0]       lon_abs;
    logic [nfua_pkg::SQLAT_W-1:0]   sq_lat;
    logic [nfua_pkg::SQLON_W-1:0]   sq_lon;
    logic [nfua_pkg::DIST_W-1:0]    dist_sum;
    logic                           take;

    assign issue   = running_reg && (cnt_reg < fill);
    assign done    = running_reg && !issue && !p0_valid_reg && !s1_valid_reg
                     && !s2_valid_reg && !s3_valid_reg;
    assign rd_en   = issue;
    assign rd_addr = cnt_reg[AW-1:0];

    // stage 1: match test and absolute coordinate differences
    assign cand = by_ident ? (rd_data.ident == q_ident)
                           : (rd_data.unit_class == q_class) && rd_data.free;
    assign lat_diff = {rd_data.lat[nfua_pkg::LAT_W-1], rd_data.lat}
                    - {q_lat[nfua_pkg::LAT_W-1], q_lat};
    assign lon_diff = {rd_data.lon[nfua_pkg::LON_W-1], rd_data.lon}
                    - {q_lon[nfua_pkg::LON_W-1], q_lon};
    assign lat_abs = lat_diff[nfua_pkg::LAT_W] ? (~lat_diff + 1'b1) : lat_diff;
    assign lon_abs = lon_diff[nfua_pkg::LON_W] ? (~lon_diff + 1'b1) : lon_diff;

    // stage 2: squares, stage 3: sum (identifier lookup ranks every match equal)
    assign sq_lat   = s1_dlat_reg * s1_dlat_reg;
    assign sq_lon   = s1_dlon_reg * s1_dlon_reg;
    assign dist_sum = by_ident ? '0
                    : nfua_pkg::DIST_W'(s2_sqlat_reg) + nfua_pkg::DIST_W'(s2_sqlon_reg);

    // stage 4: strict less-than keeps the lowest slot on ties
    assign take = s3_valid_reg && s3_cand_reg && (!found_reg || s3_dist_reg < lead_sqd_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg  <= 1'b0;
            cnt_reg      <= '0;
            p0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            p0_valid_reg <= issue;
            s1_valid_reg <= p0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (start) begin
                running_reg <= 1'b1;
                cnt_reg     <= '0;
                found_reg   <= 1'b0;
            end else begin
                if (issue) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (done) begin
                    running_reg <= 1'b0;
                end
                if (take) begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        p0_slot_reg  <= rd_addr;
        s1_cand_reg  <= cand;
        s1_slot_reg  <= p0_slot_reg;
        s1_dlat_reg  <= lat_abs[nfua_pkg::LAT_W-1:0];
        s1_dlon_reg  <= lon_abs[nfua_pkg::LON_W-1:0];
        s2_cand_reg  <= s1_cand_reg;
        s2_slot_reg  <= s1_slot_reg;
        s2_sqlat_reg <= sq_lat;
        s2_sqlon_reg <= sq_lon;
        s3_cand_reg  <= s2_cand_reg;
        s3_slot_reg  <= s2_slot_reg;
        s3_dist_reg  <= dist_sum;
        if (take) begin
            best_slot_reg <= s3_slot_reg;
            lead_sqd_reg  <= s3_dist_reg;
        end
    end

    assign stat.done  = done;
    assign stat.found = found_reg;
    assign best_slot  = best_slot_reg;

endmodule

>>> rtl/nearest_free_unit_allocator.sv
// Top level of the nearest free unit allocator: request control and result register.
//
//  channel | ports        | tdata (low bit up)                               | tuser
//  --------+--------------+--------------------------------------------------+-------
//  request | s_t*         | unit_ident, unit_class, pos_lat, pos_lon, job    | kind
//  result  | m_t*         | result_unit, slot_index, batch_assigned          | status
//
// Register and unknown kinds go from accept straight to the finish state and the result register.
// Dispatch, release, find and allocate walk the table: the table read port visits one entry
// per cycle, the distance pipeline drains and, when an entry is selected, the winning entry
// is read back for the result and any update. One request is in work at a time.
// Reset clears the entry count and batch count; the table itself needs no clearing.
// A finished result waits in the output register while the next request is taken.
module nearest_free_unit_allocator #(
    parameter int UNITS = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // unit_ident[15:0], unit_class[18:16], pos_lat[46:19], pos_lon[75:47],
    // job_ident[99:76], zero pad
    input  logic [nfua_pkg::S_DATA_W-1:0]      s_tdata,
    // kind[2:0]
    input  logic [nfua_pkg::KIND_W-1:0]        s_tuser,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // result_unit[15:0], slot_index[21:16], batch_assigned[28:22], zero pad
    output logic [nfua_pkg::M_DATA_W-1:0]      m_tdata,
    // status[2:0]
    output logic [nfua_pkg::STAT_W-1:0]        m_tuser
);

    localparam int AW = $clog2(UNITS);
    localparam int CW = $clog2(UNITS + 1);

    nfua_pkg::state_t                   state_reg, state_next;
    nfua_pkg::kind_t                    kind_reg;
    logic [nfua_pkg::IDENT_W-1:0]       ident_reg;
    logic [nfua_pkg::CLASS_W-1:0]       class_reg;
    logic signed [nfua_pkg::LAT_W-1:0]  lat_reg;
    logic signed [nfua_pkg::LON_W-1:0]  lon_reg;
    logic [nfua_pkg::JOB_W-1:0]         job_reg;
    logic                               last_reg;
    logic [CW-1:0]                      fill_reg, fill_next;
    logic [nfua_pkg::BATCH_W-1:0]       batch_reg, batch_next;
    logic                               m_valid_reg, m_valid_next;
    nfua_pkg::status_t                  m_status_reg, status_next;
    logic [nfua_pkg::IDENT_W-1:0]       m_unit_reg, unit_next;
    logic [nfua_pkg::SLOT_W-1:0]        m_slot_reg, slot_next;
    logic [nfua_pkg::BATCH_W-1:0]       m_batch_reg, report_next;

    nfua_pkg::kind_t                    in_kind;
    logic                               accept;
    logic                               in_search;
    logic                               out_free;
    logic                               commit;
    logic                               by_ident;

    logic                               srch_rd_en;
    logic [AW-1:0]                      srch_rd_addr;
    nfua_pkg::srch_stat_t               srch_stat;
    logic [AW-1:0]                      best_slot;

    logic                               tbl_wr_en, tbl_rd_en;
    logic [AW-1:0]                      tbl_wr_addr, tbl_rd_addr;
    nfua_pkg::entry_t                   tbl_wr_data, tbl_rd_data;

    assign in_kind   = nfua_pkg::kind_t'(s_tuser);
    assign in_search = (in_kind == nfua_pkg::KIND_DISPATCH)
                    || (in_kind == nfua_pkg::KIND_RELEASE)
                    || (in_kind == nfua_pkg::KIND_FIND)
                    || (in_kind == nfua_pkg::KIND_ALLOCATE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign commit    = (state_reg == nfua_pkg::ST_FINISH) && out_free;
    assign by_ident  = (kind_reg == nfua_pkg::KIND_DISPATCH)
                    || (kind_reg == nfua_pkg::KIND_RELEASE);

    nfua_table #(
        .UNITS (UNITS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    nfua_search #(
        .UNITS (UNITS)
    ) u_search (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept && in_search),
        .fill      (fill_reg),
        .by_ident  (by_ident),
        .q_ident   (ident_reg),
        .q_class   (class_reg),
        .q_lat     (lat_reg),
        .q_lon     (lon_reg),
        .rd_en     (srch_rd_en),
        .rd_addr   (srch_rd_addr),
        .rd_data   (tbl_rd_data),
        .stat      (srch_stat),
        .best_slot (best_slot)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nfua_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = in_search ? nfua_pkg::ST_SCAN : nfua_pkg::ST_FINISH;
                end
            end
            nfua_pkg::ST_SCAN: begin
                if (srch_stat.done) begin
                    state_next = srch_stat.found ? nfua_pkg::ST_FETCH
                                                 : nfua_pkg::ST_FINISH;
                end
            end
            nfua_pkg::ST_FETCH: begin
                state_next = nfua_pkg::ST_FINISH;
            end
            nfua_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = nfua_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nfua_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and updates
    always_comb begin
        s_tready     = (state_reg == nfua_pkg::ST_IDLE);
        tbl_rd_en    = srch_rd_en;
        tbl_rd_addr  = srch_rd_addr;
        tbl_wr_en    = 1'b0;
        tbl_wr_addr  = best_slot;
        tbl_wr_data  = tbl_rd_data;
        fill_next    = fill_reg;
        batch_next   = batch_reg;
        status_next  = nfua_pkg::STAT_NO_MATCH;
        unit_next    = '0;
        slot_next    = '0;
        report_next  = batch_reg;
        m_valid_next = m_valid_reg && !m_tready;

        if (state_reg == nfua_pkg::ST_FETCH) begin
            tbl_rd_en   = 1'b1;
            tbl_rd_addr = best_slot;
        end

        if (commit) begin
            m_valid_next = 1'b1;
            case (kind_reg)
                nfua_pkg::KIND_REGISTER: begin
                    if (fill_reg >= CW'(UNITS)) begin
                        status_next = nfua_pkg::STAT_FULL;
                    end else begin
                        tbl_wr_en              = 1'b1;
                        tbl_wr_addr            = fill_reg[AW-1:0];
                        tbl_wr_data.ident      = ident_reg;
                        tbl_wr_data.unit_class = class_reg;
                        tbl_wr_data.lat        = lat_reg;
                        tbl_wr_data.lon        = lon_reg;
                        tbl_wr_data.free       = 1'b1;
                        tbl_wr_data.job        = '0;
                        fill_next              = fill_reg + 1'b1;
                        status_next            = nfua_pkg::STAT_OK;
                        unit_next              = ident_reg;
                        slot_next              = nfua_pkg::SLOT_W'(fill_reg[AW-1:0]);
                    end
                end
                nfua_pkg::KIND_DISPATCH: begin
                    if (!srch_stat.found) begin
                        status_next = nfua_pkg::STAT_NOT_FOUND;
                    end else begin
                        unit_next = ident_reg;
                        slot_next = nfua_pkg::SLOT_W'(best_slot);
                        if (!tbl_rd_data.free) begin
                            status_next = nfua_pkg::STAT_BUSY;
                        end else begin
                            tbl_wr_en        = 1'b1;
                            tbl_wr_data.free = 1'b0;
                            tbl_wr_data.job  = job_reg;
                            status_next      = nfua_pkg::STAT_OK;
                        end
                    end
                end
                nfua_pkg::KIND_RELEASE: begin
                    if (!srch_stat.found) begin
                        status_next = nfua_pkg::STAT_NOT_FOUND;
                    end else begin
                        tbl_wr_en        = 1'b1;
                        tbl_wr_data.free = 1'b1;
                        tbl_wr_data.job  = '0;
                        status_next      = nfua_pkg::STAT_OK;
                        unit_next        = ident_reg;
                        slot_next        = nfua_pkg::SLOT_W'(best_slot);
                    end
                end
                nfua_pkg::KIND_FIND: begin
                    if (srch_stat.found) begin
                        status_next = nfua_pkg::STAT_OK;
                        unit_next   = tbl_rd_data.ident;
                        slot_next   = nfua_pkg::SLOT_W'(best_slot);
                    end
                end
                nfua_pkg::KIND_ALLOCATE: begin
                    if (srch_stat.found) begin
                        tbl_wr_en        = 1'b1;
                        tbl_wr_data.free = 1'b0;
                        tbl_wr_data.job  = job_reg;
                        status_next      = nfua_pkg::STAT_OK;
                        unit_next        = tbl_rd_data.ident;
                        slot_next        = nfua_pkg::SLOT_W'(best_slot);
                        if (batch_reg != nfua_pkg::BATCH_MAX) begin
                            batch_next = batch_reg + 1'b1;
                        end
                    end
                    report_next = batch_next;
                    if (last_reg) begin
                        batch_next = '0;
                    end
                end
                default: begin
                    status_next = nfua_pkg::STAT_NO_MATCH;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= nfua_pkg::ST_IDLE;
            fill_reg    <= '0;
            batch_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            batch_reg   <= batch_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg  <= in_kind;
            ident_reg <= s_tdata[15:0];
            class_reg <= s_tdata[18:16];
            lat_reg   <= $signed(s_tdata[46:19]);
            lon_reg   <= $signed(s_tdata[75:47]);
            job_reg   <= s_tdata[99:76];
            last_reg  <= s_tlast;
        end
        if (commit) begin
            m_status_reg <= status_next;
            m_unit_reg   <= unit_next;
            m_slot_reg   <= slot_next;
            m_batch_reg  <= report_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {3'b000, m_batch_reg, m_slot_reg, m_unit_reg};

endmodule
